@@ rtl/knn_pkg.sv @@
package knn_pkg;

    localparam int MAX_K_DEF   = 8;
    localparam int K_RESET     = 5;
    localparam int IDX_W       = 16;
    localparam int DIST_W      = 32;
    localparam int CLASS_W     = 8;
    localparam int RANK_W      = 3;
    localparam int K_CFG_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [DIST_W-1:0] DIST_EMPTY = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_MODE = 2'd1;

    typedef struct packed {
        logic               first;
        logic               final_req;
        logic [IDX_W-1:0]   candidate_index;
        logic [DIST_W-1:0]  candidate_distance;
        logic [CLASS_W-1:0] query_class;
        logic [CLASS_W-1:0] candidate_class;
    } t_in;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic               neighbor_valid;
        logic [IDX_W-1:0]   neighbor_index;
        logic [DIST_W-1:0]  neighbor_distance;
        logic               last;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [DIST_W-1:0]  distance;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '{valid: 1'b0, index: '0, distance: DIST_EMPTY};

    typedef struct packed {
        logic clear;
        logic ins;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_emit_state;

endpackage

@@ rtl/knn_cell.sv @@
module knn_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  knn_pkg::t_cell_ctl i_ctl,
    input  logic               i_active,
    input  knn_pkg::t_slot     i_prev,
    input  logic               i_prev_lt,
    input  knn_pkg::t_slot     i_cand,
    output knn_pkg::t_slot     o_view,
    output logic               o_lt
);

    knn_pkg::t_slot r_slot;
    knn_pkg::t_slot n_slot;

    // a clearing request empties the slot before the candidate is compared
    assign o_view = i_ctl.clear ? knn_pkg::SLOT_EMPTY : r_slot;
    assign o_lt   = i_cand.distance < o_view.distance;

    always_comb begin
        n_slot = o_view;
        if (i_ctl.ins && i_active) begin
            if (i_prev_lt) begin
                n_slot = i_prev;
            end else if (o_lt) begin
                n_slot = i_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= knn_pkg::SLOT_EMPTY;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

@@ rtl/knn_emit.sv @@
module knn_emit #(
    parameter int MAX_K = knn_pkg::MAX_K_DEF,
    parameter int KW    = $clog2(MAX_K + 1),
    parameter int RW    = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [KW-1:0]  i_k_eff,
    input  knn_pkg::t_slot i_slots [MAX_K],
    input  logic           i_out_stall,
    output logic           o_busy,
    output logic           o_out_valid,
    output knn_pkg::t_out  o_out_data
);

    knn_pkg::t_emit_state r_state;
    knn_pkg::t_emit_state n_state;
    logic [RW-1:0]        r_rank;
    logic                 r_out_valid;
    knn_pkg::t_out        r_out;
    logic                 w_load;
    logic                 w_last_sel;
    knn_pkg::t_slot       w_sel;

    assign w_last_sel = (32'(r_rank) + 32'd1) == 32'(i_k_eff);
    assign w_sel      = i_slots[r_rank];

    always_comb begin
        n_state = r_state;
        case (r_state)
            knn_pkg::ST_IDLE: begin
                if (i_start) n_state = knn_pkg::ST_EMIT;
            end
            knn_pkg::ST_EMIT: begin
                if (w_load && w_last_sel) n_state = knn_pkg::ST_IDLE;
            end
            default: n_state = knn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = 1'b0;
        w_load = 1'b0;
        case (r_state)
            knn_pkg::ST_EMIT: begin
                o_busy = 1'b1;
                // advance one rank whenever the output register is free
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_busy = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= knn_pkg::ST_IDLE;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_rank <= '0;
            end else if (w_load) begin
                r_rank <= r_rank + RW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.rank              <= 3'(r_rank);
            r_out.neighbor_valid    <= w_sel.valid;
            r_out.neighbor_index    <= w_sel.index;
            r_out.neighbor_distance <= w_sel.distance;
            r_out.last              <= w_last_sel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == knn_pkg::ST_IDLE)
        else $error("emission started while a list is still going out");

    a_start_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_rank == '0 && r_state == knn_pkg::ST_EMIT))
        else $error("emission did not begin at rank zero");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last_sel) |=> (r_state == knn_pkg::ST_IDLE && r_out_valid
                                    && r_out.last))
        else $error("sequencer kept running past the last rank");

endmodule

@@ rtl/knn_topk_selection_top.sv @@
// Top-k nearest neighbor selector for one query. Each request carries a candidate
// index, its precomputed unsigned Q16.16 distance and the query and candidate class
// labels. A row of MAX_K cells holds the list sorted nearest first; every cell
// compares the candidate against its own entry in the same cycle and either keeps
// its entry, takes the candidate, or takes its left neighbor's entry, so a request
// that does not ask for the list is done once it is taken. Insertion is by strict
// less-than, so on equal distances the earlier candidate keeps the better rank, and
// a candidate at the all-ones distance is never kept. first empties the list before
// the candidate is handled; in closed mode a candidate of another class is skipped.
// A request with final_req is followed by k results from an emission sequencer,
// one rank per cycle while the output is not stalled; input is stalled while the
// list goes out. k_in_use of 0 acts as 1 and values above MAX_K act as MAX_K.
// Configuration writes are always ready and belong only in idle periods.
module knn_topk_selection_top #(
    parameter int MAX_K = knn_pkg::MAX_K_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  knn_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output knn_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [knn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int KW = $clog2(MAX_K + 1);

    logic [knn_pkg::K_CFG_W-1:0] r_k_in_use;
    logic                        r_closed_mode;
    logic [KW-1:0]               w_k_eff;
    logic                        w_accept;
    logic                        w_pass;
    logic                        w_lt_last;
    logic                        w_busy;
    knn_pkg::t_cell_ctl          w_ctl;
    knn_pkg::t_slot              w_cand;
    knn_pkg::t_slot              w_view [MAX_K];
    logic                        w_lt   [MAX_K];
    logic                        w_active [MAX_K];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_accept    = i_in_valid && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use    <= knn_pkg::K_CFG_W'(knn_pkg::K_RESET);
            r_closed_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                knn_pkg::CFG_K_IN_USE:    r_k_in_use    <= i_cfg_data;
                knn_pkg::CFG_CLOSED_MODE: r_closed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_k_in_use == '0) begin
            w_k_eff = KW'(1);
        end else if (32'(r_k_in_use) > 32'(MAX_K)) begin
            w_k_eff = KW'(MAX_K);
        end else begin
            w_k_eff = KW'(r_k_in_use);
        end
    end

    // compare result at the last kept rank decides whether anything moves
    always_comb begin
        w_lt_last = 1'b0;
        for (int i = 0; i < MAX_K; i++) begin
            if (32'(i) + 32'd1 == 32'(w_k_eff)) w_lt_last = w_lt[i];
        end
    end

    assign w_pass = !(r_closed_mode &&
                      (i_in_data.query_class != i_in_data.candidate_class));

    assign w_ctl.clear = w_accept && i_in_data.first;
    assign w_ctl.ins   = w_accept && w_pass && w_lt_last;

    assign w_cand.valid    = 1'b1;
    assign w_cand.index    = i_in_data.candidate_index;
    assign w_cand.distance = i_in_data.candidate_distance;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        knn_pkg::t_slot w_prev;
        logic           w_prev_lt;

        if (g == 0) begin : g_head
            assign w_prev    = knn_pkg::SLOT_EMPTY;
            assign w_prev_lt = 1'b0;
        end else begin : g_body
            assign w_prev    = w_view[g-1];
            assign w_prev_lt = w_lt[g-1];
        end

        assign w_active[g] = 32'(g) < 32'(w_k_eff);

        knn_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_active  (w_active[g]),
            .i_prev    (w_prev),
            .i_prev_lt (w_prev_lt),
            .i_cand    (w_cand),
            .o_view    (w_view[g]),
            .o_lt      (w_lt[g])
        );
    end

    knn_emit #(
        .MAX_K (MAX_K),
        .KW    (KW)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && i_in_data.final_req),
        .i_k_eff     (w_k_eff),
        .i_slots     (w_view),
        .i_out_stall (i_out_stall),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.final_req) |=> o_in_stall)
        else $error("request taken while the list is going out");

    a_skip_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_pass) |-> !w_ctl.ins)
        else $error("candidate of another class inserted in closed mode");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins && !w_lt[0]) |-> !(w_cand.distance < w_view[0].distance))
        else $error("insert position does not match head compare");

endmodule

@@ verif/knn_topk_selection_top_tb.sv @@
`timescale 1ns / 1ps

module knn_topk_selection_top_tb;
    import knn_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 430;

    // Sorted top-k list kept alongside the block, plus the ranks it is due to emit.
    class topk_list_model;
        logic [K_CFG_W-1:0] k_reg;
        logic               closed_reg;
        t_slot              slots[MAX_K_DEF];
        t_out               due_ranks[$];
        int                 errors;

        function new();
            k_reg = K_CFG_W'(K_RESET);
            closed_reg = 1'b0;
            errors = 0;
            clear_slots();
        endfunction

        function void clear_slots();
            foreach (slots[s])
                slots[s] = SLOT_EMPTY;
        endfunction

        function int pending();
            return due_ranks.size();
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_K_IN_USE)
                k_reg = val[K_CFG_W-1:0];
            else if (idx == CFG_CLOSED_MODE)
                closed_reg = val[0];
        endfunction

        function int kept_count();
            if (k_reg == 0)
                return 1;
            if (k_reg > MAX_K_DEF)
                return MAX_K_DEF;
            return int'(k_reg);
        endfunction

        function void insert(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] cand_dist, int k);
            int n;
            if (!(cand_dist < slots[k-1].distance))
                return;
            n = k - 1;
            // shift farther entries down; ties stay ahead of the newcomer
            while (n > 0 && cand_dist < slots[n-1].distance) begin
                slots[n] = slots[n-1];
                n--;
            end
            slots[n] = '{valid: 1'b1, index: idx, distance: cand_dist};
        endfunction

        function void note_request(t_in req);
            int   k;
            t_out res;
            k = kept_count();
            if (req.first)
                clear_slots();
            if (!(closed_reg && req.query_class != req.candidate_class))
                insert(req.candidate_index, req.candidate_distance, k);
            if (req.final_req) begin
                for (int r = 0; r < k; r++) begin
                    res.rank = r[RANK_W-1:0];
                    res.neighbor_valid = slots[r].valid;
                    res.neighbor_index = slots[r].index;
                    res.neighbor_distance = slots[r].distance;
                    res.last = (r == k - 1);
                    due_ranks.push_back(res);
                end
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (due_ranks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: rank %0d valid %0b index %h dist %h last %0b",
                             got.rank, got.neighbor_valid, got.neighbor_index,
                             got.neighbor_distance, got.last);
                return;
            end
            want = due_ranks.pop_front();
            if (got.rank !== want.rank || got.neighbor_valid !== want.neighbor_valid ||
                got.neighbor_index !== want.neighbor_index ||
                got.neighbor_distance !== want.neighbor_distance || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected rank %0d valid %0b index %h dist %h last %0b",
                             want.rank, want.neighbor_valid, want.neighbor_index,
                             want.neighbor_distance, want.last);
                    $display("          actual   rank %0d valid %0b index %h dist %h last %0b",
                             got.rank, got.neighbor_valid, got.neighbor_index,
                             got.neighbor_distance, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in                   in_req;
    logic                  out_valid;
    logic                  out_stall;
    t_out                  out_res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    topk_list_model expected_list;
    bit             in_burst = 1'b0;
    bit             out_burst = 1'b0;
    int             quiet_cycles = 0;

    knn_topk_selection_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results before noting requests, so a result cannot match its own request's edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                expected_list.check_result(out_res);
            if (in_valid && !in_stall)
                expected_list.note_request(in_req);
            if (cfg_valid && cfg_ready)
                expected_list.write_config(cfg_index, cfg_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("knn_topk_selection_top_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: hold stall for a random count, then take one result.
    initial begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 11) == 0)
                out_burst = !out_burst;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic t_in make_request(bit first, bit fin, logic [IDX_W-1:0] idx,
                                         logic [DIST_W-1:0] cand_dist,
                                         logic [CLASS_W-1:0] qc,
                                         logic [CLASS_W-1:0] cc);
        t_in req;
        req.first = first;
        req.final_req = fin;
        req.candidate_index = idx;
        req.candidate_distance = cand_dist;
        req.query_class = qc;
        req.candidate_class = cc;
        return req;
    endfunction

    // Leaves valid high on return; drain_block or a gap in the next call lowers it.
    task automatic send_request(input t_in req);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 11) == 0)
            in_burst = !in_burst;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_list.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] k_word,
                               input logic [CFG_DATA_W-1:0] closed_word);
        write_register(CFG_K_IN_USE, k_word);
        write_register(CFG_CLOSED_MODE, closed_word);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                  sent;
        int                  q_len;
        int                  q_pos;
        logic [CLASS_W-1:0]  q_class;
        logic [K_CFG_W-1:0]  k_pick;
        t_in                 req;

        expected_list = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: k of 5, open mode; ties, zero and saturated distances
        send_request(make_request(1, 0, 16'h0000, 32'h0001_0000, 8'h00, 8'hFF));
        send_request(make_request(0, 0, 16'hFFFF, 32'h0000_0000, 8'h00, 8'hFF));
        send_request(make_request(0, 0, 16'h1234, 32'h0001_0000, 8'h00, 8'h00));
        send_request(make_request(0, 0, 16'hAAAA, DIST_EMPTY, 8'h00, 8'h00));
        send_request(make_request(0, 1, 16'h5555, 32'hFFFF_FFFE, 8'h00, 8'h00));
        send_request(make_request(1, 1, 16'h00FF, DIST_EMPTY, 8'hFF, 8'hFF));
        // overfill the list so the farthest entries fall off
        send_request(make_request(1, 0, 16'h0001, 32'h0000_0500, 8'hFF, 8'h00));
        send_request(make_request(0, 0, 16'h0002, 32'h0000_0400, 8'hFF, 8'h00));
        send_request(make_request(0, 0, 16'h0003, 32'h0000_0300, 8'hFF, 8'h00));
        send_request(make_request(0, 0, 16'h0004, 32'h0000_0200, 8'hFF, 8'h00));
        send_request(make_request(0, 0, 16'h0005, 32'h0000_0100, 8'hFF, 8'h00));
        send_request(make_request(0, 1, 16'h0006, 32'h0000_0600, 8'hFF, 8'h00));

        // k of zero acts as one; closed mode drops the class mismatch
        drain_block();
        reconfigure(4'd0, 4'hF);
        send_request(make_request(1, 1, 16'h0007, 32'h0000_0005, 8'h12, 8'h34));
        send_request(make_request(0, 1, 16'h0008, 32'h0000_0009, 8'h12, 8'h12));

        // k above the maximum, raised in the middle of a query
        drain_block();
        reconfigure(4'd15, 4'h1);
        send_request(make_request(0, 0, 16'h0009, 32'h0000_0003, 8'h12, 8'h12));
        send_request(make_request(0, 1, 16'h000A, 32'h0000_0001, 8'h12, 8'h13));

        drain_block();
        reconfigure(4'd8, 4'hE);
        send_request(make_request(1, 0, 16'h000B, 32'h0000_0007, 8'h00, 8'h01));
        send_request(make_request(0, 1, 16'h000C, 32'h0000_0007, 8'h00, 8'h02));

        // shrink k, then grow it back: the slots beyond k must be kept
        drain_block();
        reconfigure(4'd2, 4'h0);
        send_request(make_request(0, 1, 16'h000D, 32'h0000_0002, 8'h00, 8'h00));
        drain_block();
        reconfigure(4'd8, 4'h0);
        send_request(make_request(0, 1, 16'h000E, DIST_EMPTY, 8'h00, 8'h00));

        sent = 0;
        q_len = 0;
        q_pos = 0;
        q_class = '0;
        while (sent < RANDOM_ITEMS) begin
            drain_block();
            case ($urandom_range(0, 5))
                0: k_pick = 4'd0;
                1: k_pick = 4'd1;
                2: k_pick = 4'd8;
                3: k_pick = 4'd15;
                default: k_pick = 4'($urandom_range(0, 15));
            endcase
            reconfigure(k_pick, 4'($urandom_range(0, 15)));
            repeat ($urandom_range(20, 50)) begin
                if (q_len == 0) begin
                    q_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(4, 14);
                    q_pos = 0;
                    q_class = 8'($urandom_range(0, 255));
                end
                req.first = (q_pos == 0);
                req.final_req = (q_pos == q_len - 1);
                req.candidate_index = 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 5))
                    0: req.candidate_distance = $urandom;
                    1: req.candidate_distance = {13'd0, 3'($urandom_range(0, 7)), 16'd0};
                    2: req.candidate_distance = DIST_EMPTY;
                    3: req.candidate_distance = DIST_EMPTY - $urandom_range(0, 3);
                    default: req.candidate_distance = $urandom_range(0, 3);
                endcase
                req.query_class = q_class;
                req.candidate_class = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                                  : q_class;
                // break the sequence now and then
                if ($urandom_range(0, 7) == 0) begin
                    req.first = 1'($urandom_range(0, 1));
                    req.final_req = 1'($urandom_range(0, 1));
                    req.query_class = 8'($urandom_range(0, 255));
                end
                q_pos++;
                if (q_pos == q_len)
                    q_len = 0;
                send_request(req);
                sent++;
            end
        end

        drain_block();
        repeat (16) @(posedge clk);
        if (expected_list.errors == 0 && expected_list.pending() == 0)
            $display("knn_topk_selection_top_tb: done, clean");
        else
            $display("knn_topk_selection_top_tb: done, errors");
        $finish;
    end

endmodule
